FILE: hdl/brf_pkg.sv
// brf_pkg: shared types and constants for the byte ring fifo with commit and rollback
// command and result codes, default sizes, controller to datapath structs
// no dependencies
package brf_pkg;

	// default sizes
	localparam int DEPTH_DEF     = 256;
	localparam int MAX_BURST_DEF = 64;

	// field widths
	localparam int CMD_W    = 3;
	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 8;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_BLOCK  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ACK    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_NACK   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd6;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd7;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic accept;   // latch the incoming command, read the head byte
		logic exec;     // carry out the latched command
		logic burst;    // emit one byte of a block peek
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free; // output register can take a result this cycle
		logic blk_go;   // latched command is a block peek with bytes to send
		logic rem_one;  // current burst byte is the final one
	} dp_status_t;

endpackage

FILE: hdl/byte_ring_fifo_with_commit_rollback.sv
// byte_ring_fifo_with_commit_rollback: top level of the byte ring fifo
// joins the brf_ctrl state machine and the brf_datapath
// depends on brf_pkg, brf_ctrl, brf_datapath
//
// usage
// - slave stream carries commands: push, pop, peek head, peek block, ack, nack,
//   flush and remove; ring holds up to DEPTH-1 bytes
// - master stream carries results; every command gives one result, a block peek
//   gives one result per byte read, and tlast marks the final one
// - a block peek moves the tentative pointer past the bytes sent; ack commits
//   it into the read pointer, nack rolls it back
// - a command is accepted in idle and carried out in execute, which registers its result;
//   a block peek's bytes then leave from the burst state one by one, paced by the
//   one-port registered byte memory
// - a new command is taken only once the previous one has finished; the output
//   register lets that happen while its last result still waits
// - when the receiver stalls, the output register holds its result and the
//   block stops, both in mid burst and before executing the next command
// - reset clears all three pointers and the output valid; memory contents are
//   not cleared, an empty ring never returns them
module byte_ring_fifo_with_commit_rollback import brf_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int MAX_BURST = MAX_BURST_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // cmd[2:0], data_in[10:3], count[17:11], zero pad
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // data_out[7:0], status[9:8], fill[17:10], zero pad
	output logic        m_tlast
);

	ctrl_cmd_t           ctrl;
	dp_status_t          dp_st;
	logic [BYTE_W-1:0]   out_data;
	logic [STATUS_W-1:0] out_status;
	logic [FILL_W-1:0]   out_fill;

	// sequencer: idle, execute, burst
	brf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.dp_st    (dp_st),
		.ctrl     (ctrl)
	);

	// pointers, byte memory and result register
	brf_datapath #(
		.DEPTH     (DEPTH),
		.MAX_BURST (MAX_BURST)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.dp_st      (dp_st),
		.in_cmd     (s_tdata[2:0]),
		.in_data    (s_tdata[10:3]),
		.in_count   (s_tdata[17:11]),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.out_data   (out_data),
		.out_status (out_status),
		.out_fill   (out_fill),
		.out_last   (m_tlast)
	);

	// pack result fields, lowest first
	assign m_tdata = {6'd0, out_fill, out_status, out_data};

endmodule

FILE: hdl/brf_ctrl.sv
// brf_ctrl: sequencing state machine of the byte ring fifo
// steps idle, execute and burst; drives commands into brf_datapath
// depends on brf_pkg
module brf_ctrl import brf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t dp_st,
	output ctrl_cmd_t  ctrl
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_BURST = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d     = state_q;
		ctrl.accept = 1'b0;
		ctrl.exec   = 1'b0;
		ctrl.burst  = 1'b0;
		s_tready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready    = 1'b1;
				ctrl.accept = s_tvalid;
				if (s_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (dp_st.out_free) begin
					ctrl.exec = 1'b1;
					state_d   = dp_st.blk_go ? S_BURST : S_IDLE;
				end
			end
			S_BURST: begin
				if (dp_st.out_free) begin
					ctrl.burst = 1'b1;
					if (dp_st.rem_one) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hdl/brf_datapath.sv
// brf_datapath: pointers, byte memory and result register of the byte ring fifo
// acts on commands from brf_ctrl and reports status back
// depends on brf_pkg
module brf_datapath import brf_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int MAX_BURST = MAX_BURST_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_cmd_t           ctrl,
	output dp_status_t          dp_st,
	input  logic [CMD_W-1:0]    in_cmd,
	input  logic [BYTE_W-1:0]   in_data,
	input  logic [COUNT_W-1:0]  in_count,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic [BYTE_W-1:0]   out_data,
	output logic [STATUS_W-1:0] out_status,
	output logic [FILL_W-1:0]   out_fill,
	output logic                out_last
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DW = PW + 1;
	localparam int CW = (DW > COUNT_W) ? DW : COUNT_W;
	localparam int XW = (DW > FILL_W) ? DW : FILL_W;

	function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] p, input logic [DW-1:0] n);
		logic [DW-1:0] s;
		s = DW'(p) + n;
		if (s >= DW'(DEPTH)) begin
			s = s - DW'(DEPTH);
		end
		return s[PW-1:0];
	endfunction

	function automatic logic [DW-1:0] fill_of(input logic [PW-1:0] w, input logic [PW-1:0] r);
		if (w >= r) begin
			return DW'(w) - DW'(r);
		end
		return DW'(DEPTH) - (DW'(r) - DW'(w));
	endfunction

	logic [BYTE_W-1:0] mem [DEPTH];

	logic [PW-1:0]      rd_pos_q, wr_pos_q, tn_pos_q;
	logic [PW-1:0]      rd_pos_d, wr_pos_d, tn_pos_d;
	logic [CMD_W-1:0]   cmd_q;
	logic [BYTE_W-1:0]  din_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [BYTE_W-1:0]  rd_data_q;
	logic [PW-1:0]      burst_pos_q;
	logic [COUNT_W-1:0] rem_q;

	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_data_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [FILL_W-1:0]   out_fill_q;
	logic                out_last_q;

	logic [DW-1:0]      fill_cur, fill_nxt;
	logic [XW-1:0]      fill_ext;
	logic [CW-1:0]      cnt_w, fill_w, n_w;
	logic               empty, full, rm_all;
	logic               mem_we;
	logic               rd_en;
	logic [PW-1:0]      rd_addr;
	logic               load;
	logic [BYTE_W-1:0]  res_data;
	logic [STATUS_W-1:0] res_status;
	logic               res_last;

	assign fill_cur = fill_of(wr_pos_q, rd_pos_q);
	assign empty    = (fill_cur == '0);
	assign full     = (fill_cur >= DW'(DEPTH - 1));
	assign cnt_w    = CW'(cnt_q);
	assign fill_w   = CW'(fill_cur);
	assign rm_all   = (cnt_w >= fill_w);

	// burst length: smallest of count, max burst and fill
	always_comb begin
		n_w = cnt_w;
		if (n_w > CW'(MAX_BURST)) begin
			n_w = CW'(MAX_BURST);
		end
		if (n_w > fill_w) begin
			n_w = fill_w;
		end
	end

	assign dp_st.out_free = !out_valid_q || m_tready;
	assign dp_st.blk_go   = (cmd_q == CMD_BLOCK) && (n_w != '0);
	assign dp_st.rem_one  = (rem_q == COUNT_W'(1));

	// command execution
	always_comb begin
		rd_pos_d   = rd_pos_q;
		wr_pos_d   = wr_pos_q;
		tn_pos_d   = tn_pos_q;
		mem_we     = 1'b0;
		load       = 1'b0;
		res_data   = '0;
		res_status = ST_OK;
		res_last   = 1'b1;
		if (ctrl.exec) begin
			load = 1'b1;
			case (cmd_q)
				CMD_PUSH: begin
					if (full) begin
						res_status = ST_FULL;
					end else begin
						mem_we   = 1'b1;
						wr_pos_d = ring_add(wr_pos_q, DW'(1));
					end
				end
				CMD_POP: begin
					if (empty) begin
						res_status = ST_EMPTY;
					end else begin
						res_data = rd_data_q;
						rd_pos_d = ring_add(rd_pos_q, DW'(1));
					end
				end
				CMD_PEEK: begin
					if (empty) begin
						res_status = ST_EMPTY;
					end else begin
						res_data = rd_data_q;
					end
				end
				CMD_BLOCK: begin
					tn_pos_d = ring_add(rd_pos_q, n_w[DW-1:0]);
					if (n_w != '0) begin
						load = 1'b0;
					end else if (empty) begin
						res_status = ST_EMPTY;
					end
				end
				CMD_ACK: begin
					rd_pos_d = tn_pos_q;
				end
				CMD_NACK: begin
					tn_pos_d = rd_pos_q;
				end
				CMD_FLUSH: begin
					rd_pos_d = '0;
					wr_pos_d = '0;
					tn_pos_d = '0;
				end
				CMD_REMOVE: begin
					if (rm_all) begin
						rd_pos_d = '0;
						wr_pos_d = '0;
						tn_pos_d = '0;
					end else begin
						rd_pos_d = ring_add(rd_pos_q, cnt_w[DW-1:0]);
						tn_pos_d = rd_pos_d;
					end
				end
				default: begin
					load = 1'b1;
				end
			endcase
		end else if (ctrl.burst) begin
			load     = 1'b1;
			res_data = rd_data_q;
			res_last = dp_st.rem_one;
		end
	end

	assign fill_nxt = fill_of(wr_pos_d, rd_pos_d);
	assign fill_ext = XW'(fill_nxt);

	// head read on accept, next burst byte while more remain
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_pos_q;
		if (ctrl.accept) begin
			rd_en = 1'b1;
		end else if (ctrl.burst && !dp_st.rem_one) begin
			rd_en   = 1'b1;
			rd_addr = burst_pos_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_pos_q] <= din_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			cmd_q <= in_cmd;
			din_q <= in_data;
			cnt_q <= in_count;
		end
		if (ctrl.exec) begin
			burst_pos_q <= ring_add(rd_pos_q, DW'(1));
			rem_q       <= n_w[COUNT_W-1:0];
		end else if (ctrl.burst) begin
			burst_pos_q <= ring_add(burst_pos_q, DW'(1));
			rem_q       <= rem_q - COUNT_W'(1);
		end
		if (load) begin
			out_data_q   <= res_data;
			out_status_q <= res_status;
			out_fill_q   <= fill_ext[FILL_W-1:0];
			out_last_q   <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pos_q    <= '0;
			wr_pos_q    <= '0;
			tn_pos_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pos_q <= rd_pos_d;
			wr_pos_q <= wr_pos_d;
			tn_pos_q <= tn_pos_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid   = out_valid_q;
	assign out_data   = out_data_q;
	assign out_status = out_status_q;
	assign out_fill   = out_fill_q;
	assign out_last   = out_last_q;

endmodule
